>>> rtl/core/bscr_pkg.sv
`default_nettype none

package bscr_pkg;

    // sensor kind codes held in the configuration register
    localparam logic [2:0] KIND_UNUSED  = 3'd0;
    localparam logic [2:0] KIND_HEART   = 3'd1;
    localparam logic [2:0] KIND_POWER   = 3'd2;
    localparam logic [2:0] KIND_SPEED   = 3'd3;
    localparam logic [2:0] KIND_CADENCE = 3'd4;
    localparam logic [2:0] KIND_BOTH    = 3'd5;

    // stale counters
    localparam logic [3:0] STALE_LIMIT     = 4'd12;
    localparam logic [3:0] STALE_MAX       = 4'd15;
    localparam logic [2:0] PWR_STALE_LIMIT = 3'd6;
    localparam logic [2:0] PWR_STALE_MAX   = 3'd7;

    // work queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // divider retires two quotient bits per cycle over a 32 bit quotient
    localparam int          DIV_BITS    = 32;
    localparam int          DIV_STEPS   = DIV_BITS / 2;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        MEAS_SPEED   = 3'd0,
        MEAS_CADENCE = 3'd1,
        MEAS_POWER   = 3'd2,
        MEAS_HEART   = 3'd3,
        MEAS_REQUEST = 3'd4
    } t_meas;

    // one result to be produced: either a literal (num << 8) or
    // the rate num * 61440 * 256 / den
    typedef struct packed {
        logic        divide;
        t_meas       meas;
        logic [15:0] num;
        logic [15:0] den;
    } t_job;

    // all results caused by one accepted input transaction
    typedef struct packed {
        logic [2:0] source;
        logic       has_second;
        t_job       job0;
        t_job       job1;
    } t_entry;

    typedef struct packed {
        t_meas       meas;
        logic [2:0]  source;
        logic [31:0] value;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/bike_sensor_rate_calculator_unit.sv
// channel    | direction | handshake            | payload
// -----------+-----------+----------------------+----------------------------------------
// input      | in        | push / full          | ten decoded broadcast fields
// result     | out       | pop / empty          | measure kind, source kind, Q24.8 value, last
// config     | in        | i_cfg_wr_en          | sensor kind (3 bits)
//
// an input transaction is taken whenever the two-entry work queue has room
// a literal or saturated result goes from setup to hand-over, other rates pass setup,
// the two-bit divider steps and hand-over; a speed and cadence broadcast divides twice
// reset is synchronous and clears the configuration, the stored broadcast and the queue
// a held result stalls the divider only; the front keeps accepting until the queue fills
`default_nettype none

module bike_sensor_rate_calculator_unit
    import bscr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_wr_data,

    // input queue side
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_cadence_time,
    input  wire logic [15:0] i_pedal_revolutions,
    input  wire logic [15:0] i_speed_time,
    input  wire logic [15:0] i_wheel_revolutions,
    input  wire logic [15:0] i_heart_rate_time,
    input  wire logic [7:0]  i_heart_rate_bpm,
    input  wire logic        i_power_only_page,
    input  wire logic [7:0]  i_power_event_count,
    input  wire logic [15:0] i_power_watts,
    input  wire logic [7:0]  i_power_cadence,

    // result queue side
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_measure_kind,
    output logic [2:0]       o_source_kind,
    output logic [31:0]      o_value_q8,
    output logic             o_last_of_run
);

    logic    accept;
    logic    fe_push;
    t_entry  fe_entry;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_entry  q_head;
    logic    out_valid;
    t_result out_data;

    // the front accepts whenever the queue can take a full entry
    assign full   = q_full;
    assign accept = push && !q_full;

    // front: holds the previous broadcast and stale counters, classifies each
    // transaction into up to two pending results
    bscr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_accept            (accept),
        .i_cadence_time      (i_cadence_time),
        .i_pedal_revolutions (i_pedal_revolutions),
        .i_speed_time        (i_speed_time),
        .i_wheel_revolutions (i_wheel_revolutions),
        .i_heart_rate_time   (i_heart_rate_time),
        .i_heart_rate_bpm    (i_heart_rate_bpm),
        .i_power_only_page   (i_power_only_page),
        .i_power_event_count (i_power_event_count),
        .i_power_watts       (i_power_watts),
        .i_power_cadence     (i_power_cadence),
        .o_push              (fe_push),
        .o_entry             (fe_entry)
    );

    // decoupling queue; a transaction with no result pushes nothing
    bscr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (fe_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: serial rate divider and registered result slot
    bscr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_out       (out_data)
    );

    assign empty          = !out_valid;
    assign o_measure_kind = out_data.meas;
    assign o_source_kind  = out_data.source;
    assign o_value_q8     = out_data.value;
    assign o_last_of_run  = out_data.last;

endmodule

`default_nettype wire

>>> rtl/core/bscr_queue.sv
`default_nettype none

module bscr_queue
    import bscr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_data,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bscr_front.sv
`default_nettype none

module bscr_front
    import bscr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_wr_data,
    input  wire logic        i_accept,
    input  wire logic [15:0] i_cadence_time,
    input  wire logic [15:0] i_pedal_revolutions,
    input  wire logic [15:0] i_speed_time,
    input  wire logic [15:0] i_wheel_revolutions,
    input  wire logic [15:0] i_heart_rate_time,
    input  wire logic [7:0]  i_heart_rate_bpm,
    input  wire logic        i_power_only_page,
    input  wire logic [7:0]  i_power_event_count,
    input  wire logic [15:0] i_power_watts,
    input  wire logic [7:0]  i_power_cadence,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [2:0]  r_sensor_kind;
    logic        r_first_seen;
    logic [15:0] r_prev_cadence_time;
    logic [15:0] r_prev_pedal_revs;
    logic [15:0] r_prev_speed_time;
    logic [15:0] r_prev_wheel_revs;
    logic [15:0] r_prev_heart_time;
    logic [7:0]  r_prev_power_event;
    logic        r_power_seen;
    logic [3:0]  r_shared_stale;
    logic [3:0]  r_speed_stale;
    logic [2:0]  r_power_stale;

    logic        n_first_seen;
    logic [7:0]  n_prev_power_event;
    logic        n_power_seen;
    logic [3:0]  n_shared_stale;
    logic [3:0]  n_speed_stale;
    logic [2:0]  n_power_stale;

    logic        kind_used;
    logic [15:0] cad_dt;
    logic [15:0] cad_dr;
    logic [15:0] spd_dt;
    logic [15:0] spd_dr;
    logic [3:0]  shared_bump;
    logic [3:0]  speed_bump;
    logic [2:0]  power_bump;

    t_job        cad_job;
    logic        cad_valid;
    logic [3:0]  cad_stale;
    t_job        spd_job;
    logic        spd_valid;
    logic [3:0]  spd_stale;

    t_job        slot_a;
    t_job        slot_b;
    logic        valid_a;
    logic        valid_b;

    function automatic t_job make_job(logic divide, t_meas meas, logic [15:0] num,
                                      logic [15:0] den);
        t_job j;
        j.divide = divide;
        j.meas   = meas;
        j.num    = num;
        j.den    = den;
        return j;
    endfunction

    assign kind_used   = (r_sensor_kind != KIND_UNUSED) && (r_sensor_kind <= KIND_BOTH);
    assign cad_dt      = i_cadence_time - r_prev_cadence_time;
    assign cad_dr      = i_pedal_revolutions - r_prev_pedal_revs;
    assign spd_dt      = i_speed_time - r_prev_speed_time;
    assign spd_dr      = i_wheel_revolutions - r_prev_wheel_revs;
    assign shared_bump = (r_shared_stale < STALE_MAX) ? r_shared_stale + 1'b1 : STALE_MAX;
    assign speed_bump  = (r_speed_stale < STALE_MAX) ? r_speed_stale + 1'b1 : STALE_MAX;
    assign power_bump  = (r_power_stale < PWR_STALE_MAX) ? r_power_stale + 1'b1
                                                         : PWR_STALE_MAX;

    // rate outcome of the crank and wheel channels
    always_comb begin
        if (cad_dt != '0) begin
            cad_job   = make_job(1'b1, MEAS_CADENCE, cad_dr, cad_dt);
            cad_valid = 1'b1;
            cad_stale = '0;
        end else begin
            cad_job   = make_job(1'b0, MEAS_CADENCE, '0, '0);
            cad_valid = (shared_bump >= STALE_LIMIT);
            cad_stale = shared_bump;
        end
        if (spd_dt != '0) begin
            spd_job   = make_job(1'b1, MEAS_SPEED, spd_dr, spd_dt);
            spd_valid = 1'b1;
            spd_stale = '0;
        end else begin
            spd_job   = make_job(1'b0, MEAS_SPEED, '0, '0);
            spd_valid = (speed_bump >= STALE_LIMIT);
            spd_stale = speed_bump;
        end
    end

    always_comb begin
        n_first_seen       = r_first_seen;
        n_prev_power_event = r_prev_power_event;
        n_power_seen       = r_power_seen;
        n_shared_stale     = r_shared_stale;
        n_speed_stale      = r_speed_stale;
        n_power_stale      = r_power_stale;
        slot_a             = make_job(1'b0, MEAS_REQUEST, '0, '0);
        slot_b             = make_job(1'b0, MEAS_REQUEST, '0, '0);
        valid_a            = 1'b0;
        valid_b            = 1'b0;

        if (i_accept && kind_used) begin
            if (!r_first_seen) begin
                // first broadcast only asks for the device id
                n_first_seen = 1'b1;
                valid_a      = 1'b1;
            end else begin
                case (r_sensor_kind)
                    KIND_HEART: begin
                        if (i_heart_rate_time != r_prev_heart_time) begin
                            n_shared_stale = '0;
                            valid_a        = 1'b1;
                            slot_a = make_job(1'b0, MEAS_HEART, {8'd0, i_heart_rate_bpm}, '0);
                        end else begin
                            n_shared_stale = shared_bump;
                            valid_a        = (shared_bump >= STALE_LIMIT);
                            slot_a         = make_job(1'b0, MEAS_HEART, '0, '0);
                        end
                    end
                    KIND_POWER: begin
                        if (i_power_only_page) begin
                            if (r_power_seen) begin
                                if (r_prev_power_event != i_power_event_count) begin
                                    n_power_stale = '0;
                                    valid_a = 1'b1;
                                    valid_b = 1'b1;
                                    slot_a  = make_job(1'b0, MEAS_POWER, i_power_watts, '0);
                                    slot_b  = make_job(1'b0, MEAS_CADENCE,
                                                       {8'd0, i_power_cadence}, '0);
                                end else begin
                                    // stale power gives cadence then power, both zero
                                    n_power_stale = power_bump;
                                    valid_a = (power_bump >= PWR_STALE_LIMIT);
                                    valid_b = (power_bump >= PWR_STALE_LIMIT);
                                    slot_a  = make_job(1'b0, MEAS_CADENCE, '0, '0);
                                    slot_b  = make_job(1'b0, MEAS_POWER, '0, '0);
                                end
                            end
                            n_prev_power_event = i_power_event_count;
                            n_power_seen       = 1'b1;
                        end
                    end
                    KIND_SPEED: begin
                        slot_a        = spd_job;
                        valid_a       = spd_valid;
                        n_speed_stale = spd_stale;
                    end
                    KIND_CADENCE: begin
                        slot_a         = cad_job;
                        valid_a        = cad_valid;
                        n_shared_stale = cad_stale;
                    end
                    KIND_BOTH: begin
                        slot_a         = cad_job;
                        valid_a        = cad_valid;
                        n_shared_stale = cad_stale;
                        slot_b         = spd_job;
                        valid_b        = spd_valid;
                        n_speed_stale  = spd_stale;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // pack the results to the front of the entry
    always_comb begin
        o_push             = valid_a || valid_b;
        o_entry.source     = r_sensor_kind;
        o_entry.has_second = valid_a && valid_b;
        o_entry.job0       = valid_a ? slot_a : slot_b;
        o_entry.job1       = slot_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_kind       <= KIND_UNUSED;
            r_first_seen        <= 1'b0;
            r_prev_cadence_time <= '0;
            r_prev_pedal_revs   <= '0;
            r_prev_speed_time   <= '0;
            r_prev_wheel_revs   <= '0;
            r_prev_heart_time   <= '0;
            r_prev_power_event  <= '0;
            r_power_seen        <= 1'b0;
            r_shared_stale      <= '0;
            r_speed_stale       <= '0;
            r_power_stale       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sensor_kind <= i_cfg_wr_data;
            end
            r_first_seen       <= n_first_seen;
            r_prev_power_event <= n_prev_power_event;
            r_power_seen       <= n_power_seen;
            r_shared_stale     <= n_shared_stale;
            r_speed_stale      <= n_speed_stale;
            r_power_stale      <= n_power_stale;
            if (i_accept && kind_used) begin
                r_prev_cadence_time <= i_cadence_time;
                r_prev_pedal_revs   <= i_pedal_revolutions;
                r_prev_speed_time   <= i_speed_time;
                r_prev_wheel_revs   <= i_wheel_revolutions;
                r_prev_heart_time   <= i_heart_rate_time;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bscr_back.sv
`default_nettype none

module bscr_back
    import bscr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  wire t_entry i_q_head,
    output logic        o_q_pop,
    input  wire logic   i_out_pop,
    output logic        o_out_valid,
    output t_result     o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic                 r_slot;
    logic [15:0]          r_rem;
    logic [31:0]          r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    t_result              r_out;

    t_job        cur;
    logic        cur_last;
    logic [19:0] num15;
    logic        sat;
    logic [16:0] t1;
    logic [16:0] t2;
    logic [16:0] rem1;
    logic [16:0] rem2;
    logic [31:0] quo1;
    logic [31:0] quo2;
    logic        ge1;
    logic        ge2;
    logic        out_free;

    assign cur      = r_slot ? i_q_head.job1 : i_q_head.job0;
    assign cur_last = r_slot || !i_q_head.has_second;
    // 61440 * 256 = 15 << 20
    assign num15    = {cur.num, 4'd0} - {4'd0, cur.num};
    assign sat      = ({8'd0, num15[19:12]} >= cur.den);
    assign out_free = !r_out_valid || i_out_pop;

    // two restoring division steps per cycle
    always_comb begin
        t1   = {r_rem, r_quo[31]};
        ge1  = (t1 >= {1'b0, cur.den});
        rem1 = ge1 ? t1 - {1'b0, cur.den} : t1;
        quo1 = {r_quo[30:0], ge1};
        t2   = {rem1[15:0], quo1[31]};
        ge2  = (t2 >= {1'b0, cur.den});
        rem2 = ge2 ? t2 - {1'b0, cur.den} : t2;
        quo2 = {quo1[30:0], ge2};
    end

    assign o_q_pop     = (r_state == ST_DONE) && out_free && cur_last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cnt <= '0;
                        if (!cur.divide) begin
                            r_quo   <= {8'd0, cur.num, 8'd0};
                            r_state <= ST_DONE;
                        end else if (sat) begin
                            r_quo   <= '1;
                            r_state <= ST_DONE;
                        end else begin
                            r_rem   <= {8'd0, num15[19:12]};
                            r_quo   <= {num15[11:0], 20'd0};
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem <= rem2[15:0];
                    r_quo <= quo2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out.meas   <= cur.meas;
                        r_out.source <= i_q_head.source;
                        r_out.value  <= r_quo;
                        r_out.last   <= cur_last;
                        r_slot       <= !cur_last;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
